// ----- sv/rwc_pkg.sv -----
// Shared types and constants for the RGB window convolution block.
// No dependencies; every other file imports this package.
package rwc_pkg;

  localparam int CH_W          = 8;
  localparam int NUM_CH        = 3;
  localparam int PIX_W         = CH_W * NUM_CH;
  localparam int LINE_WIDTH_W  = 11;
  localparam int COEF_W        = 16;
  localparam int COEFS_PER_PACK = 4;
  localparam int COEF_PACKS    = 7;
  localparam int COEF_PACK_W   = COEF_W * COEFS_PER_PACK;
  localparam int PROD_W        = CH_W + 1 + COEF_W;
  localparam int APB_DATA_W    = 64;
  localparam int APB_ADDR_W    = 6;
  localparam int REG_IDX_W     = 3;

  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 11'd1024;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LINE_WIDTH,
    REG_COEF_A,
    REG_COEF_B,
    REG_COEF_C,
    REG_COEF_D,
    REG_COEF_E,
    REG_COEF_F,
    REG_COEF_G
  } reg_idx_t;

  typedef logic [COEF_PACKS-1:0][COEF_PACK_W-1:0] coef_bank_t;

  typedef struct packed {
    logic valid;
    logic row_end;
    logic frame_end;
  } win_ctrl_t;

endpackage

// ----- sv/rwc_if.sv -----
// Pixel stream interfaces for the RGB window convolution block.
// Depends on rwc_pkg for the channel width.
interface rwc_in_if import rwc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] pix_blue;
  logic [CH_W-1:0] pix_green;
  logic [CH_W-1:0] pix_red;
  logic            frame_start;
  logic            frame_end;

  modport source (output valid, pix_blue, pix_green, pix_red, frame_start, frame_end,
                  input ready);
  modport sink (input valid, pix_blue, pix_green, pix_red, frame_start, frame_end,
                output ready);
endinterface

interface rwc_out_if import rwc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_blue;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_red;
  logic            row_done;
  logic            frame_done;

  modport source (output valid, out_blue, out_green, out_red, row_done, frame_done,
                  input ready);
  modport sink (input valid, out_blue, out_green, out_red, row_done, frame_done,
                output ready);
endinterface

// ----- sv/rwc_regs.sv -----
// APB-style configuration registers: line width and packed kernel coefficients.
// Depends on rwc_pkg.
module rwc_regs import rwc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_ADDR_W-1:0]   paddr,
  input  logic [APB_DATA_W-1:0]   pwdata,
  output logic [APB_DATA_W-1:0]   prdata,
  output logic                    pready,
  output logic [LINE_WIDTH_W-1:0] line_width,
  output coef_bank_t              coef_packs
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1 -: REG_IDX_W]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RESET;
      coef_packs <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_LINE_WIDTH: line_width <= pwdata[LINE_WIDTH_W-1:0];
        REG_COEF_A:     coef_packs[0] <= pwdata;
        REG_COEF_B:     coef_packs[1] <= pwdata;
        REG_COEF_C:     coef_packs[2] <= pwdata;
        REG_COEF_D:     coef_packs[3] <= pwdata;
        REG_COEF_E:     coef_packs[4] <= pwdata;
        REG_COEF_F:     coef_packs[5] <= pwdata;
        REG_COEF_G:     coef_packs[6] <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LINE_WIDTH: prdata = APB_DATA_W'(line_width);
      REG_COEF_A:     prdata = coef_packs[0];
      REG_COEF_B:     prdata = coef_packs[1];
      REG_COEF_C:     prdata = coef_packs[2];
      REG_COEF_D:     prdata = coef_packs[3];
      REG_COEF_E:     prdata = coef_packs[4];
      REG_COEF_F:     prdata = coef_packs[5];
      REG_COEF_G:     prdata = coef_packs[6];
      default:        prdata = '0;
    endcase
  end

endmodule

// ----- sv/rwc_line_buf.sv -----
// Raster position counters, line store memory with read-modify-write, and window registers.
// Depends on rwc_pkg and rwc_in_if.
module rwc_line_buf import rwc_pkg::*; #(
  parameter int KERNEL_SIZE = 3,
  parameter int MAX_LINE    = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [LINE_WIDTH_W-1:0] line_width,
  rwc_in_if.sink                  pix_in,
  output logic [KERNEL_SIZE*KERNEL_SIZE-1:0][PIX_W-1:0] window,
  output win_ctrl_t               win_ctrl,
  input  logic                    win_ready
);

  localparam int HIST   = KERNEL_SIZE - 1;
  localparam int ADDR_W = $clog2(MAX_LINE);
  localparam int COL_W  = $clog2(MAX_LINE + 1);
  localparam int ROWS_W = $clog2(KERNEL_SIZE);
  localparam int CMP_W  = (COL_W > LINE_WIDTH_W) ? COL_W : LINE_WIDTH_W;

  logic [COL_W-1:0]  column_count, col_base, col_c, col_inc;
  logic [ROWS_W-1:0] rows_seen, rows_base, rows_next;
  logic [CMP_W-1:0]  lw_ext, width_eff;
  logic [ADDR_W-1:0] rd_addr, s1_addr;
  logic [PIX_W-1:0]  in_pix, s1_pix;
  logic              item_res, item_row_end;
  logic              in_fire, free1, free2, wr_en;
  logic              v1, s1_res, s1_row_end, s1_fend, fwd;
  win_ctrl_t         s2_ctrl;

  logic [HIST-1:0][PIX_W-1:0] mem [MAX_LINE];
  logic [HIST-1:0][PIX_W-1:0] rd_q, fwd_data, older, wdata;
  logic [HIST:0][PIX_W-1:0]   slice;

  assign in_pix = {pix_in.pix_red, pix_in.pix_green, pix_in.pix_blue};

  always_comb begin
    lw_ext = CMP_W'(line_width);
    if (lw_ext < CMP_W'(KERNEL_SIZE)) begin
      width_eff = CMP_W'(KERNEL_SIZE);
    end else if (lw_ext > CMP_W'(MAX_LINE)) begin
      width_eff = CMP_W'(MAX_LINE);
    end else begin
      width_eff = lw_ext;
    end
    col_base  = pix_in.frame_start ? '0 : column_count;
    rows_base = pix_in.frame_start ? '0 : rows_seen;
    col_c     = (col_base >= COL_W'(MAX_LINE - 1)) ? COL_W'(MAX_LINE - 1) : col_base;
    col_inc   = col_c + COL_W'(1);
    rd_addr   = col_c[ADDR_W-1:0];
    item_res  = (rows_base >= ROWS_W'(HIST)) && (col_c >= COL_W'(HIST));
    item_row_end = (CMP_W'(col_c) + CMP_W'(1)) >= width_eff;
    rows_next = (item_row_end && (rows_base < ROWS_W'(HIST))) ?
                rows_base + ROWS_W'(1) : rows_base;
  end

  assign free2        = !s2_ctrl.valid || win_ready;
  assign wr_en        = v1 && free2;
  assign free1        = !v1 || free2;
  assign pix_in.ready = free1;
  assign in_fire      = pix_in.valid && free1;

  assign older = fwd ? fwd_data : rd_q;
  assign slice = {s1_pix, older};
  assign wdata = slice[HIST:1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr] <= wdata;
    end
    if (in_fire) begin
      rd_q       <= mem[rd_addr];
      fwd        <= wr_en && (s1_addr == rd_addr);
      fwd_data   <= wdata;
      s1_pix     <= in_pix;
      s1_addr    <= rd_addr;
      s1_res     <= item_res;
      s1_row_end <= item_row_end;
      s1_fend    <= pix_in.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      rows_seen    <= '0;
      v1           <= 1'b0;
      s2_ctrl      <= '0;
      window       <= '0;
    end else begin
      if (in_fire) begin
        column_count <= item_row_end ? '0 : col_inc;
        rows_seen    <= rows_next;
      end
      if (free1) begin
        v1 <= pix_in.valid;
      end
      if (free2) begin
        s2_ctrl.valid     <= v1 && s1_res;
        s2_ctrl.row_end   <= s1_row_end;
        s2_ctrl.frame_end <= s1_fend;
      end
      if (wr_en) begin
        for (int i = 0; i < KERNEL_SIZE; i++) begin
          for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
            window[i*KERNEL_SIZE + j] <= window[i*KERNEL_SIZE + j + 1];
          end
          window[i*KERNEL_SIZE + KERNEL_SIZE - 1] <= slice[i];
        end
      end
    end
  end

  assign win_ctrl = s2_ctrl;

endmodule

// ----- sv/rwc_mac.sv -----
// Per-channel multiply, row and total sums, scaling and saturation, output register.
// Depends on rwc_pkg and rwc_out_if.
module rwc_mac import rwc_pkg::*; #(
  parameter int KERNEL_SIZE    = 3,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic       clk,
  input  logic       rst,
  input  coef_bank_t coef_packs,
  input  logic [KERNEL_SIZE*KERNEL_SIZE-1:0][PIX_W-1:0] window,
  input  win_ctrl_t  win_ctrl,
  output logic       win_ready,
  rwc_out_if.source  pix_out
);

  localparam int TAPS  = KERNEL_SIZE * KERNEL_SIZE;
  localparam int ROW_W = PROD_W + $clog2(KERNEL_SIZE);
  localparam int ACC_W = ROW_W + $clog2(KERNEL_SIZE);

  logic signed [COEF_W-1:0] coef [TAPS];
  logic signed [PROD_W-1:0] prod_c [NUM_CH][TAPS];
  logic signed [PROD_W-1:0] p_prod [NUM_CH][TAPS];
  logic signed [ROW_W-1:0]  row_c [NUM_CH][KERNEL_SIZE];
  logic signed [ROW_W-1:0]  r_row [NUM_CH][KERNEL_SIZE];
  logic signed [ACC_W-1:0]  tot_c [NUM_CH];
  logic signed [ACC_W-1:0]  t_tot [NUM_CH];
  logic [CH_W-1:0]          fin_c [NUM_CH];
  logic [CH_W-1:0]          o_ch [NUM_CH];
  win_ctrl_t                p_ctrl, r_ctrl, t_ctrl, o_ctrl;
  logic                     free_p, free_r, free_t, free_o;

  for (genvar k = 0; k < TAPS; k++) begin : g_coef
    localparam int P = k / COEFS_PER_PACK;
    localparam int L = k % COEFS_PER_PACK;
    assign coef[k] = coef_packs[P][COEF_W*L +: COEF_W];
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int k = 0; k < TAPS; k++) begin
        prod_c[ch][k] = $signed({1'b0, window[k][CH_W*ch +: CH_W]}) * coef[k];
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int i = 0; i < KERNEL_SIZE; i++) begin
        row_c[ch][i] = '0;
        for (int j = 0; j < KERNEL_SIZE; j++) begin
          row_c[ch][i] = row_c[ch][i] + ROW_W'(p_prod[ch][i*KERNEL_SIZE + j]);
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      tot_c[ch] = '0;
      for (int i = 0; i < KERNEL_SIZE; i++) begin
        tot_c[ch] = tot_c[ch] + ACC_W'(r_row[ch][i]);
      end
    end
  end

  // The sign test makes every negative sum land at zero; sums above the channel range saturate.
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (t_tot[ch][ACC_W-1]) begin
        fin_c[ch] = '0;
      end else if (|t_tot[ch][ACC_W-2:COEF_FRAC_BITS+CH_W]) begin
        fin_c[ch] = '1;
      end else begin
        fin_c[ch] = t_tot[ch][COEF_FRAC_BITS +: CH_W];
      end
    end
  end

  assign free_o    = !o_ctrl.valid || pix_out.ready;
  assign free_t    = !t_ctrl.valid || free_o;
  assign free_r    = !r_ctrl.valid || free_t;
  assign free_p    = !p_ctrl.valid || free_r;
  assign win_ready = free_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_ctrl <= '0;
      r_ctrl <= '0;
      t_ctrl <= '0;
      o_ctrl <= '0;
    end else begin
      if (free_p) begin
        p_ctrl <= win_ctrl;
      end
      if (free_r) begin
        r_ctrl <= p_ctrl;
      end
      if (free_t) begin
        t_ctrl <= r_ctrl;
      end
      if (free_o) begin
        o_ctrl <= t_ctrl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free_p && win_ctrl.valid) begin
      p_prod <= prod_c;
    end
    if (free_r && p_ctrl.valid) begin
      r_row <= row_c;
    end
    if (free_t && r_ctrl.valid) begin
      t_tot <= tot_c;
    end
    if (free_o && t_ctrl.valid) begin
      o_ch <= fin_c;
    end
  end

  assign pix_out.valid      = o_ctrl.valid;
  assign pix_out.row_done   = o_ctrl.row_end;
  assign pix_out.frame_done = o_ctrl.frame_end;
  assign pix_out.out_blue   = o_ch[0];
  assign pix_out.out_green  = o_ch[1];
  assign pix_out.out_red    = o_ch[2];

endmodule

// ----- sv/rgb_window_convolution_top.sv -----
// Throughput: one pixel per clock unless the output stalls; the line store is read at
// acceptance and written back when the first stage moves on, with forwarding when the
// same column is touched twice in a row. A pixel completing a window passes through the
// line store read, window shift, multiply, row sums, total and output register stages.
// Reset clears counters, pipeline valids, window and registers; the line store is not
// cleared and needs no clearing pass, so the block accepts pixels right after reset.
module rgb_window_convolution_top import rwc_pkg::*; #(
  parameter int KERNEL_SIZE    = 3,
  parameter int MAX_LINE       = 1024,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  rwc_in_if.sink                pix_in,
  rwc_out_if.source             pix_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int TAPS = KERNEL_SIZE * KERNEL_SIZE;

  logic [LINE_WIDTH_W-1:0]     line_width;
  coef_bank_t                  coef_packs;
  logic [TAPS-1:0][PIX_W-1:0]  window;
  win_ctrl_t                   win_ctrl;
  logic                        win_ready;

  rwc_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .line_width (line_width),
    .coef_packs (coef_packs)
  );

  rwc_line_buf #(
    .KERNEL_SIZE (KERNEL_SIZE),
    .MAX_LINE    (MAX_LINE)
  ) u_line_buf (
    .clk        (clk),
    .rst        (rst),
    .line_width (line_width),
    .pix_in     (pix_in),
    .window     (window),
    .win_ctrl   (win_ctrl),
    .win_ready  (win_ready)
  );

  rwc_mac #(
    .KERNEL_SIZE    (KERNEL_SIZE),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .coef_packs (coef_packs),
    .window     (window),
    .win_ctrl   (win_ctrl),
    .win_ready  (win_ready),
    .pix_out    (pix_out)
  );

endmodule

// ----- sv/rwc_checker.sv -----
// Port-level assertions for the RGB window convolution top level, attached by bind.
// Depends on rwc_pkg and rgb_window_convolution_top.
module rwc_checker import rwc_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [NUM_CH*CH_W+1:0]   out_data
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Output beat changed while stalled.");

  a_ready_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("Input held off while the output side was not stalled.");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> in_ready && !out_valid)
    else $error("Pipeline not empty after reset.");

  a_no_beat_during_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output beat produced out of reset.");

endmodule

bind rgb_window_convolution_top rwc_checker u_rwc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix_in.valid),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .out_data  ({pix_out.out_red, pix_out.out_green, pix_out.out_blue,
               pix_out.row_done, pix_out.frame_done})
);
